// ===== design/bfr_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bfr_pkg
// Shared types and constants of the bit field reader: request codes,
// sequencer states and the interface of the shared bit extraction unit.
// ----------------------------------------------------------------------------
package bfr_pkg;

    localparam int BUF_BYTES_DEF     = 4096;
    localparam int MAX_FIELD_BITS    = 32;
    localparam logic [31:0] MSB_OVERRUN_VALUE = 32'h0000_ffff;

    typedef enum logic [1:0] {
        REQ_LOAD = 2'd0,
        REQ_BIT  = 2'd1,
        REQ_LSB  = 2'd2,
        REQ_MSB  = 2'd3
    } req_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_LSB,
        S_MSB,
        S_ADJ,
        S_EMIT
    } state_t;

    // one step of the extraction unit: a buffer byte and the running field
    typedef struct packed {
        logic [7:0]  data;
        logic [2:0]  bit_pos;
        logic [5:0]  left;
        logic        msb_first;
        logic [31:0] acc;
        logic [5:0]  got;
    } xtr_req_t;

    typedef struct packed {
        logic [31:0] acc;
        logic [3:0]  take;
        logic        whole;
    } xtr_rsp_t;

endpackage

// ===== design/bfr_byte_mem.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bfr_byte_mem
// Byte buffer: one write port, one registered read port. A read of the
// address being written returns the new byte.
// ----------------------------------------------------------------------------
module bfr_byte_mem #(
    parameter int DEPTH = bfr_pkg::BUF_BYTES_DEF,
    localparam int AW   = $clog2(DEPTH)
) (
    input  logic          clk,
    input  logic          we,
    input  logic [AW-1:0] waddr,
    input  logic [7:0]    wdata,
    input  logic [AW-1:0] raddr,
    output logic [7:0]    rdata
);

    logic [7:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        if (we && (waddr == raddr))
        begin
            rdata <= wdata;
        end
        else
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

// ===== design/bfr_extract.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bfr_extract
// Shared extraction unit: takes the usable bits of one buffer byte and
// merges them into the running field, LSB first or MSB first.
// ----------------------------------------------------------------------------
module bfr_extract
(
    input  bfr_pkg::xtr_req_t req,
    output bfr_pkg::xtr_rsp_t rsp
);
    import bfr_pkg::*;

    logic [3:0]  avail;
    logic        whole;
    logic [3:0]  take;
    logic [7:0]  mask;
    logic [7:0]  bits;
    logic [31:0] acc;

    always_comb
    begin
        avail = 4'd8 - {1'b0, req.bit_pos};
        whole = (req.left >= {2'b00, avail});
        take  = whole ? avail : req.left[3:0];
        mask  = 8'hff >> (4'd8 - take);
        if (req.msb_first)
        begin
            // top bits of what is left in the byte
            bits = (req.data >> (avail - take)) & mask;
            acc  = (req.acc << take) | {24'd0, bits};
        end
        else
        begin
            bits = (req.data >> req.bit_pos) & mask;
            acc  = req.acc | ({24'd0, bits} << req.got);
        end
        rsp.acc   = acc;
        rsp.take  = take;
        rsp.whole = whole;
    end

endmodule

// ===== design/bit_field_reader.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bit_field_reader
// Byte buffer with a read cursor answering bit and field read requests.
// ----------------------------------------------------------------------------
// Usage:
//   Request channel (req_valid/req_ready) carries one word per request.
//   A load word is written to the buffer in the cycle it is taken and gives
//   no result; loads can follow each other in every cycle.
//   Read words (bit, LSB-first field, MSB-first field) each give one result
//   word on the result channel (res_valid/res_ready).
//   A read is accepted, then steps through the shared extraction unit once
//   per buffer byte touched (4 or 5 for a 32-bit field), repeats that for
//   each escape, takes one adder step per escape, and then loads the output
//   register. req_ready is low while a read is in progress.
//   The result register holds a word until it is taken; while a held word
//   is not taken, a finished read waits in its last state and no new word is taken.
//   Reset empties the buffer and rewinds the cursor at once; buffer bytes
//   themselves are not cleared and are never read before being loaded.
// ----------------------------------------------------------------------------
module bit_field_reader #(
    parameter int BUF_BYTES = bfr_pkg::BUF_BYTES_DEF
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               req_valid,
    output logic               req_ready,
    input  logic [1:0]         req_type,
    input  logic [7:0]         load_byte,
    input  logic               restart_buffer,
    input  logic [5:0]         field_width,
    input  logic               sign_given,
    input  logic               negative,
    output logic               res_valid,
    input  logic               res_ready,
    output logic signed [31:0] value,
    output logic               out_of_data
);
    import bfr_pkg::*;

    localparam int AW = $clog2(BUF_BYTES);
    localparam int CW = $clog2(BUF_BYTES + 1);
    localparam int EW = $clog2(8 * BUF_BYTES + 1);

    state_t          state_reg, state_next;
    logic [CW-1:0]   fill_reg, fill_next;
    logic [CW-1:0]   byte_pos_reg, byte_pos_next;
    logic [2:0]      bit_pos_reg, bit_pos_next;
    logic            res_valid_reg, res_valid_next;

    logic [31:0]     acc_reg, acc_next;
    logic [5:0]      got_reg, got_next;
    logic [5:0]      left_reg, left_next;
    logic [5:0]      width_reg, width_next;
    logic            sg_reg, sg_next;
    logic            neg_reg, neg_next;
    logic [EW-1:0]   esc_reg, esc_next;
    logic [31:0]     val_reg, val_next;
    logic            ood_reg, ood_next;
    logic [31:0]     value_reg, value_next;
    logic            out_of_data_reg, out_of_data_next;

    logic            accept;
    logic [5:0]      w_in;
    logic            mem_we;
    logic [AW-1:0]   mem_waddr;
    logic [7:0]      mem_q;
    logic [CW-1:0]   load_base;

    xtr_req_t        xreq;
    xtr_rsp_t        xrsp;

    logic            at_end;
    logic [5:0]      left_after;
    logic [CW-1:0]   pos_inc;
    logic            lsb_done;
    logic            msb_fail;
    logic            msb_done;
    logic [31:0]     raw;
    logic [31:0]     high;
    logic [31:0]     wmask;
    logic            is_escape;
    logic [31:0]     lsb_val;
    logic            emit_free;

    assign req_ready   = (state_reg == S_IDLE);
    assign accept      = req_valid && req_ready;
    assign res_valid   = res_valid_reg;
    assign value       = value_reg;
    assign out_of_data = out_of_data_reg;

    assign w_in = (field_width > 6'(MAX_FIELD_BITS)) ? 6'(MAX_FIELD_BITS) : field_width;

    bfr_byte_mem #(
        .DEPTH (BUF_BYTES)
    ) u_mem (
        .clk   (clk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (load_byte),
        .raddr (byte_pos_next[AW-1:0]),
        .rdata (mem_q)
    );

    assign xreq.data      = mem_q;
    assign xreq.bit_pos   = bit_pos_reg;
    assign xreq.left      = left_reg;
    assign xreq.msb_first = (state_reg == S_MSB);
    assign xreq.acc       = acc_reg;
    assign xreq.got       = got_reg;

    bfr_extract u_extract (
        .req (xreq),
        .rsp (xrsp)
    );

    // status of the current extraction step
    always_comb
    begin
        at_end     = (byte_pos_reg >= fill_reg);
        left_after = left_reg - {2'b00, xrsp.take};
        pos_inc    = byte_pos_reg + 1'b1;
        lsb_done   = !at_end && (left_after == 6'd0);
        msb_fail   = at_end || (xrsp.whole && (left_after != 6'd0) && (pos_inc >= fill_reg));
        msb_done   = !msb_fail && (left_after == 6'd0);
        raw        = xrsp.acc;
        high       = 32'd1 << (width_reg - 6'd1);
        wmask      = (width_reg == 6'd32) ? 32'hffff_ffff : ((32'd1 << width_reg) - 32'd1);
        is_escape  = (raw == high);
        if (sg_reg)
        begin
            lsb_val = neg_reg ? (32'd0 - raw) : raw;
        end
        else if ((raw & high) != 32'd0)
        begin
            lsb_val = raw | ~wmask;
        end
        else
        begin
            lsb_val = raw;
        end
        emit_free  = !res_valid_reg || res_ready;
        load_base  = restart_buffer ? '0 : fill_reg;
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    case (req_t'(req_type))
                        REQ_LOAD: state_next = S_IDLE;
                        REQ_BIT:  state_next = S_LSB;
                        REQ_LSB:  state_next = (w_in == 6'd0) ? S_EMIT : S_LSB;
                        REQ_MSB:  state_next = S_MSB;
                        default:  state_next = S_IDLE;
                    endcase
                end
            end
            S_LSB:
            begin
                if (at_end)
                begin
                    state_next = (!sg_reg && (esc_reg != '0)) ? S_ADJ : S_EMIT;
                end
                else if (lsb_done)
                begin
                    if (sg_reg)
                    begin
                        state_next = S_EMIT;
                    end
                    else if (is_escape)
                    begin
                        state_next = S_LSB;
                    end
                    else
                    begin
                        state_next = (esc_reg != '0) ? S_ADJ : S_EMIT;
                    end
                end
            end
            S_MSB:
            begin
                if (msb_fail || msb_done)
                begin
                    state_next = S_EMIT;
                end
            end
            S_ADJ:
            begin
                if (esc_reg == EW'(1))
                begin
                    state_next = S_EMIT;
                end
            end
            S_EMIT:
            begin
                if (emit_free)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // datapath and outputs
    always_comb
    begin
        fill_next        = fill_reg;
        byte_pos_next    = byte_pos_reg;
        bit_pos_next     = bit_pos_reg;
        res_valid_next   = res_valid_reg && !res_ready;
        acc_next         = acc_reg;
        got_next         = got_reg;
        left_next        = left_reg;
        width_next       = width_reg;
        sg_next          = sg_reg;
        neg_next         = neg_reg;
        esc_next         = esc_reg;
        val_next         = val_reg;
        ood_next         = ood_reg;
        value_next       = value_reg;
        out_of_data_next = out_of_data_reg;
        mem_we           = 1'b0;
        mem_waddr        = load_base[AW-1:0];

        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    acc_next   = 32'd0;
                    got_next   = 6'd0;
                    esc_next   = '0;
                    val_next   = 32'd0;
                    ood_next   = 1'b0;
                    width_next = w_in;
                    left_next  = w_in;
                    sg_next    = sign_given;
                    neg_next   = negative;
                    case (req_t'(req_type))
                        REQ_LOAD:
                        begin
                            if (restart_buffer)
                            begin
                                byte_pos_next = '0;
                                bit_pos_next  = 3'd0;
                            end
                            fill_next = load_base;
                            // drop the byte when the buffer is full
                            if (load_base < CW'(BUF_BYTES))
                            begin
                                mem_we    = 1'b1;
                                fill_next = load_base + 1'b1;
                            end
                        end
                        REQ_BIT:
                        begin
                            width_next = 6'd1;
                            left_next  = 6'd1;
                            sg_next    = 1'b1;
                            neg_next   = 1'b0;
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end
            S_LSB:
            begin
                if (at_end)
                begin
                    val_next = 32'd0;
                    ood_next = 1'b1;
                end
                else
                begin
                    if (xrsp.whole)
                    begin
                        byte_pos_next = pos_inc;
                        bit_pos_next  = 3'd0;
                    end
                    else
                    begin
                        bit_pos_next = bit_pos_reg + xrsp.take[2:0];
                    end
                    acc_next  = xrsp.acc;
                    got_next  = got_reg + {2'b00, xrsp.take};
                    left_next = left_after;
                    if (lsb_done)
                    begin
                        val_next = lsb_val;
                        if (!sg_reg && is_escape)
                        begin
                            // escape: count it and read another field
                            esc_next  = esc_reg + 1'b1;
                            acc_next  = 32'd0;
                            got_next  = 6'd0;
                            left_next = width_reg;
                        end
                    end
                end
            end
            S_MSB:
            begin
                if (at_end)
                begin
                    val_next = MSB_OVERRUN_VALUE;
                    ood_next = 1'b1;
                end
                else
                begin
                    acc_next  = xrsp.acc;
                    left_next = left_after;
                    if (xrsp.whole)
                    begin
                        byte_pos_next = pos_inc;
                        // keep the bit position when the data runs out
                        if (!msb_fail)
                        begin
                            bit_pos_next = 3'd0;
                        end
                    end
                    else
                    begin
                        bit_pos_next = bit_pos_reg + xrsp.take[2:0];
                    end
                    if (msb_fail)
                    begin
                        val_next = MSB_OVERRUN_VALUE;
                        ood_next = 1'b1;
                    end
                    else if (msb_done)
                    begin
                        val_next = xrsp.acc;
                    end
                end
            end
            S_ADJ:
            begin
                if (val_reg[31])
                begin
                    val_next = val_reg - (high - 32'd1);
                end
                else
                begin
                    val_next = val_reg + (high - 32'd1);
                end
                esc_next = esc_reg - 1'b1;
            end
            S_EMIT:
            begin
                if (emit_free)
                begin
                    res_valid_next   = 1'b1;
                    value_next       = val_reg;
                    out_of_data_next = ood_reg;
                end
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            fill_reg      <= '0;
            byte_pos_reg  <= '0;
            bit_pos_reg   <= 3'd0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            fill_reg      <= fill_next;
            byte_pos_reg  <= byte_pos_next;
            bit_pos_reg   <= bit_pos_next;
            res_valid_reg <= res_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        acc_reg         <= acc_next;
        got_reg         <= got_next;
        left_reg        <= left_next;
        width_reg       <= width_next;
        sg_reg          <= sg_next;
        neg_reg         <= neg_next;
        esc_reg         <= esc_next;
        val_reg         <= val_next;
        ood_reg         <= ood_next;
        value_reg       <= value_next;
        out_of_data_reg <= out_of_data_next;
    end

    // ------------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------------
    a_cursor_in_data: assert property (@(posedge clk) disable iff (!rst_n)
        byte_pos_reg <= fill_reg)
        else $error("read cursor beyond loaded data");

    a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
        fill_reg <= CW'(BUF_BYTES))
        else $error("fill count beyond buffer size");

    a_load_keeps_cursor: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && (req_type == REQ_LOAD) && !restart_buffer)
        |=> (byte_pos_reg == $past(byte_pos_reg)) && (bit_pos_reg == $past(bit_pos_reg)))
        else $error("load without restart moved the cursor");

    a_result_from_emit: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(res_valid_reg) |-> ($past(state_reg) == S_EMIT))
        else $error("result word raised outside emit");

    a_adj_has_escapes: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_ADJ) |-> (esc_reg != '0))
        else $error("escape adjustment with no escapes pending");

endmodule
